>>> rtl/pst_pkg.sv
package pst_pkg;

    // Signed fixed-point coordinate as carried on the channels.
    typedef logic signed [31:0] t_fix;

    // Opcodes of an input item.
    localparam logic [1:0] OP_SET  = 2'd0;
    localparam logic [1:0] OP_STEP = 2'd1;
    localparam logic [1:0] OP_ADD  = 2'd2;
    localparam logic [1:0] OP_REL  = 2'd3;

    // Clamp a 33-bit signed value to the signed 32-bit range.
    function automatic t_fix sat32(input logic [32:0] v);
        t_fix r;
        if (v[32] != v[31]) begin
            r = v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

>>> rtl/pst_in_if.sv
interface pst_in_if import pst_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    t_fix       operand_x;
    t_fix       operand_y;

    modport source (output valid, output opcode, output operand_x, output operand_y,
                    input ready);
    modport sink (input valid, input opcode, input operand_x, input operand_y,
                  output ready);
endinterface

>>> rtl/pst_out_if.sv
interface pst_out_if import pst_pkg::*; ();
    logic valid;
    logic ready;
    t_fix pos_x;
    t_fix pos_y;
    t_fix rel_x;
    t_fix rel_y;

    modport source (output valid, output pos_x, output pos_y, output rel_x, output rel_y,
                    input ready);
    modport sink (input valid, input pos_x, input pos_y, input rel_x, input rel_y,
                  output ready);
endinterface

>>> rtl/pst_mul.sv
module pst_mul (
    input  logic        i_clk,
    input  logic [32:0] i_a,
    input  logic [32:0] i_b,
    output logic [65:0] o_p
);

    logic [63:0] w_lo;
    logic [65:0] w_cross_a;
    logic [65:0] w_cross_b;
    logic [65:0] w_top;

    // One 32x32 product; the top operand bits add shifted copies of the other operand.
    assign w_lo      = i_a[31:0] * i_b[31:0];
    assign w_cross_a = i_a[32] ? {2'b0, i_b[31:0], 32'b0} : 66'd0;
    assign w_cross_b = i_b[32] ? {2'b0, i_a[31:0], 32'b0} : 66'd0;
    assign w_top     = (i_a[32] & i_b[32]) ? {2'b01, 64'b0} : 66'd0;

    // The product is registered before anything uses it.
    always_ff @(posedge i_clk) begin
        o_p <= {2'b0, w_lo} + w_cross_a + w_cross_b + w_top;
    end

endmodule

>>> rtl/pst_trial.sv
module pst_trial (
    input  logic [35:0] i_a,
    input  logic [35:0] i_b,
    output logic [35:0] o_diff,
    output logic        o_ge
);

    logic [36:0] w_sub;

    // Trial subtraction shared by the square root and the divider.
    assign w_sub  = {1'b0, i_a} - {1'b0, i_b};
    assign o_diff = w_sub[35:0];
    assign o_ge   = ~w_sub[36];

endmodule

>>> rtl/point_step_toward_target.sv
// Tracks a 2D position in signed fixed point and answers each input transfer with one
// result transfer. Set, shift and relative items go straight to the result state. A step
// item whose target lies within the step speed is done once the squares are compared; a
// real step goes on to a bit-serial square root and two restoring divisions, all running
// through one shared trial subtractor, and uses the shared 33x33 multiplier for the
// squares and the scaled offsets. One item is in work at a time; a new item is taken
// while a finished result still waits on the output.
// step_speed lies at address 0 of the APB port and resets to 1.0.
module point_step_toward_target import pst_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pst_in_if.sink      i_in,
    pst_out_if.source   o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [30:0] SPEED_RESET = 31'(1) << FRAC_BITS;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_ABS  = 4'd1;
    localparam logic [3:0] S_SQX  = 4'd2;
    localparam logic [3:0] S_SQY  = 4'd3;
    localparam logic [3:0] S_SQS  = 4'd4;
    localparam logic [3:0] S_SUM  = 4'd5;
    localparam logic [3:0] S_CMP  = 4'd6;
    localparam logic [3:0] S_SQRT = 4'd7;
    localparam logic [3:0] S_MULA = 4'd8;
    localparam logic [3:0] S_MULB = 4'd9;
    localparam logic [3:0] S_MULW = 4'd10;
    localparam logic [3:0] S_DIVX = 4'd11;
    localparam logic [3:0] S_DIVY = 4'd12;
    localparam logic [3:0] S_UPD  = 4'd13;
    localparam logic [3:0] S_FIN  = 4'd14;

    localparam logic [5:0] SQRT_LAST = 6'd32;
    localparam logic [5:0] DIV_LAST  = 6'd30;

    // Control and state registers.
    logic [3:0]  r_state;
    logic [5:0]  r_cnt;
    logic        r_ovalid;
    logic [30:0] r_speed;
    t_fix        r_pos_x;
    t_fix        r_pos_y;

    // Working registers.
    t_fix        r_ox;
    t_fix        r_oy;
    logic [32:0] r_dx;
    logic [32:0] r_dy;
    logic [32:0] r_mx;
    logic [32:0] r_my;
    logic [65:0] r_xsq;
    logic [65:0] r_ysq;
    logic [61:0] r_qsq;
    logic [65:0] r_sum;
    logic [65:0] r_rad;
    logic [35:0] r_rem;
    logic [32:0] r_root;
    logic [32:0] r_dist;
    logic [62:0] r_ny;
    logic [30:0] r_ax;
    t_fix        r_out_px;
    t_fix        r_out_py;
    t_fix        r_out_rx;
    t_fix        r_out_ry;

    logic        w_in_xfer;
    logic        w_out_free;
    logic        w_cfg_wr;
    logic [32:0] w_mul_a;
    logic [32:0] w_mul_b;
    logic [65:0] w_prod;
    logic [35:0] w_tr_a;
    logic [35:0] w_tr_b;
    logic [35:0] w_tr_diff;
    logic        w_tr_ge;
    logic [32:0] w_step_x;
    logic [32:0] w_step_y;

    assign w_in_xfer  = i_in.valid & i_in.ready;
    assign w_out_free = ~r_ovalid | o_out.ready;
    assign w_cfg_wr   = psel & penable & pwrite & (paddr[2] == 1'b0);

    // Handshake and register port.
    assign i_in.ready  = (r_state == S_IDLE);
    assign o_out.valid = r_ovalid;
    assign o_out.pos_x = r_out_px;
    assign o_out.pos_y = r_out_py;
    assign o_out.rel_x = r_out_rx;
    assign o_out.rel_y = r_out_ry;
    assign pready      = 1'b1;
    assign prdata      = (paddr[2] == 1'b0) ? {1'b0, r_speed} : 32'd0;

    // Operand selection for the shared multiplier.
    always_comb begin
        unique case (r_state)
            S_SQX:   begin w_mul_a = r_mx;            w_mul_b = r_mx;            end
            S_SQY:   begin w_mul_a = r_my;            w_mul_b = r_my;            end
            S_SQS:   begin w_mul_a = {2'b0, r_speed}; w_mul_b = {2'b0, r_speed}; end
            S_MULA:  begin w_mul_a = r_mx;            w_mul_b = {2'b0, r_speed}; end
            S_MULB:  begin w_mul_a = r_my;            w_mul_b = {2'b0, r_speed}; end
            default: begin w_mul_a = 33'd0;           w_mul_b = 33'd0;           end
        endcase
    end

    pst_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_p   (w_prod)
    );

    // Operand selection for the shared trial subtractor.
    always_comb begin
        unique case (r_state)
            S_SQRT: begin
                w_tr_a = {r_rem[33:0], r_rad[65:64]};
                w_tr_b = {1'b0, r_root, 2'b01};
            end
            S_DIVX, S_DIVY: begin
                w_tr_a = {2'b0, r_rem[32:0], r_rad[65]};
                w_tr_b = {3'b0, r_dist};
            end
            default: begin
                w_tr_a = 36'd0;
                w_tr_b = 36'd0;
            end
        endcase
    end

    pst_trial u_trial (
        .i_a    (w_tr_a),
        .i_b    (w_tr_b),
        .o_diff (w_tr_diff),
        .o_ge   (w_tr_ge)
    );

    // Position after a step: the quotient moves each axis toward the target.
    assign w_step_x = r_dx[32] ? ({r_pos_x[31], r_pos_x} - {2'b0, r_ax})
                               : ({r_pos_x[31], r_pos_x} + {2'b0, r_ax});
    assign w_step_y = r_dy[32] ? ({r_pos_y[31], r_pos_y} - {2'b0, r_root[30:0]})
                               : ({r_pos_y[31], r_pos_y} + {2'b0, r_root[30:0]});

    // Sequencer, position and speed register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= 6'd0;
            r_ovalid <= 1'b0;
            r_speed  <= SPEED_RESET;
            r_pos_x  <= '0;
            r_pos_y  <= '0;
        end else begin
            if (w_cfg_wr) begin
                r_speed <= pwdata[30:0];
            end
            if (r_state == S_FIN && w_out_free) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && o_out.ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_xfer) begin
                        unique case (i_in.opcode)
                            OP_SET: begin
                                r_pos_x <= i_in.operand_x;
                                r_pos_y <= i_in.operand_y;
                                r_state <= S_FIN;
                            end
                            OP_STEP: r_state <= S_ABS;
                            OP_ADD: begin
                                r_pos_x <= sat32({r_pos_x[31], r_pos_x}
                                                 + {i_in.operand_x[31], i_in.operand_x});
                                r_pos_y <= sat32({r_pos_y[31], r_pos_y}
                                                 + {i_in.operand_y[31], i_in.operand_y});
                                r_state <= S_FIN;
                            end
                            default: r_state <= S_FIN;
                        endcase
                    end
                end
                S_ABS:  r_state <= S_SQX;
                S_SQX:  r_state <= S_SQY;
                S_SQY:  r_state <= S_SQS;
                S_SQS:  r_state <= S_SUM;
                S_SUM:  r_state <= S_CMP;
                S_CMP: begin
                    if (r_sum > {4'b0, r_qsq}) begin
                        r_cnt   <= SQRT_LAST;
                        r_state <= S_SQRT;
                    end else begin
                        r_pos_x <= r_ox;
                        r_pos_y <= r_oy;
                        r_state <= S_FIN;
                    end
                end
                S_SQRT: begin
                    r_cnt <= r_cnt - 6'd1;
                    if (r_cnt == 6'd0) begin
                        r_state <= S_MULA;
                    end
                end
                S_MULA: r_state <= S_MULB;
                S_MULB: begin
                    r_cnt   <= DIV_LAST;
                    r_state <= S_MULW;
                end
                S_MULW: r_state <= S_DIVX;
                S_DIVX: begin
                    if (r_cnt == 6'd0) begin
                        r_cnt   <= DIV_LAST;
                        r_state <= S_DIVY;
                    end else begin
                        r_cnt <= r_cnt - 6'd1;
                    end
                end
                S_DIVY: begin
                    r_cnt <= r_cnt - 6'd1;
                    if (r_cnt == 6'd0) begin
                        r_state <= S_UPD;
                    end
                end
                S_UPD: begin
                    r_pos_x <= sat32(w_step_x);
                    r_pos_y <= sat32(w_step_y);
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Datapath registers of the step computation and the result register.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    r_ox <= i_in.operand_x;
                    r_oy <= i_in.operand_y;
                    r_dx <= {i_in.operand_x[31], i_in.operand_x} - {r_pos_x[31], r_pos_x};
                    r_dy <= {i_in.operand_y[31], i_in.operand_y} - {r_pos_y[31], r_pos_y};
                end
            end
            S_ABS: begin
                r_mx <= r_dx[32] ? (33'd0 - r_dx) : r_dx;
                r_my <= r_dy[32] ? (33'd0 - r_dy) : r_dy;
            end
            S_SQY: r_xsq <= w_prod;
            S_SQS: r_ysq <= w_prod;
            S_SUM: begin
                r_qsq <= w_prod[61:0];
                r_sum <= r_xsq + r_ysq;
            end
            S_CMP: begin
                r_rad  <= r_sum;
                r_rem  <= 36'd0;
                r_root <= 33'd0;
            end
            // One root bit per cycle from two radicand bits.
            S_SQRT: begin
                r_rem  <= w_tr_ge ? w_tr_diff : w_tr_a;
                r_root <= {r_root[31:0], w_tr_ge};
                r_rad  <= {r_rad[63:0], 2'b00};
                if (r_cnt == 6'd0) begin
                    r_dist <= {r_root[31:0], w_tr_ge};
                end
            end
            // The x numerator arrives; load the divider.
            S_MULB: begin
                r_rem  <= {4'b0, w_prod[62:31]};
                r_rad  <= {w_prod[30:0], 35'b0};
                r_root <= 33'd0;
            end
            S_MULW: r_ny <= w_prod[62:0];
            // One quotient bit per cycle; the y division follows the x division.
            S_DIVX, S_DIVY: begin
                if (r_state == S_DIVX && r_cnt == 6'd0) begin
                    r_ax   <= {r_root[29:0], w_tr_ge};
                    r_rem  <= {4'b0, r_ny[62:31]};
                    r_rad  <= {r_ny[30:0], 35'b0};
                    r_root <= 33'd0;
                end else begin
                    r_rem  <= w_tr_ge ? w_tr_diff : w_tr_a;
                    r_root <= {r_root[31:0], w_tr_ge};
                    r_rad  <= {r_rad[64:0], 1'b0};
                end
            end
            S_FIN: begin
                if (w_out_free) begin
                    r_out_px <= r_pos_x;
                    r_out_py <= r_pos_y;
                    r_out_rx <= sat32({r_ox[31], r_ox} - {r_pos_x[31], r_pos_x});
                    r_out_ry <= sat32({r_oy[31], r_oy} - {r_pos_y[31], r_pos_y});
                end
            end
            default: begin
            end
        endcase
    end

    // An accepted item always starts work.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> r_state != S_IDLE)
        else $error("item accepted but sequencer stayed idle");

    // The divider remainder stays below the distance.
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIVX || r_state == S_DIVY) |-> r_rem < {3'b0, r_dist})
        else $error("divider remainder not below divisor");

    // A step along an axis never exceeds the speed.
    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_UPD |-> (r_ax <= r_speed && r_root[30:0] <= r_speed))
        else $error("step longer than speed");

    // The last y quotient bit leads to the position update.
    a_div_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIVY && r_cnt == 6'd0) |=> r_state == S_UPD)
        else $error("division did not end in update");

endmodule

>>> sim/pst_checker.sv
module pst_checker import pst_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pst_in_if.sink     i_mon_in,
    pst_out_if.sink    i_mon_out,
    input  logic       i_cfg_we,
    input  logic [30:0] i_cfg_speed,
    output int         o_errors,
    output int         o_pending,
    output int         o_results
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        t_fix pos_x;
        t_fix pos_y;
        t_fix rel_x;
        t_fix rel_y;
    } t_result;

    t_result expected_results[$];
    longint  track_x;
    longint  track_y;
    longint  speed;

    // Clamp a wide signed value to the 32-bit range.
    function automatic longint clamp32(longint v);
        longint r;
        r = v;
        if (v > 64'sd2147483647) r = 64'sd2147483647;
        if (v < -64'sd2147483648) r = -64'sd2147483648;
        return r;
    endfunction

    // Floor square root of a value below 2^66.
    function automatic logic [32:0] floor_sqrt(logic [65:0] v);
        logic [32:0] r;
        logic [32:0] c;
        r = '0;
        for (int b = 32; b >= 0; b--) begin
            c = r | (33'd1 << b);
            if ({33'd0, c} * {33'd0, c} <= v) r = c;
        end
        return r;
    endfunction

    // Work out the position update and the result of one input item.
    function automatic t_result predict_move(logic [1:0] op, t_fix ox, t_fix oy);
        t_result     res;
        longint      dx;
        longint      dy;
        logic [32:0] mx;
        logic [32:0] my;
        logic [65:0] dist_sq;
        logic [65:0] speed_sq;
        logic [32:0] root_len;
        logic [63:0] ax;
        logic [63:0] ay;
        case (op)
            OP_SET: begin
                track_x = ox;
                track_y = oy;
            end
            OP_STEP: begin
                dx = longint'(ox) - track_x;
                dy = longint'(oy) - track_y;
                mx = dx < 0 ? 33'(-dx) : 33'(dx);
                my = dy < 0 ? 33'(-dy) : 33'(dy);
                dist_sq = {33'd0, mx} * {33'd0, mx} + {33'd0, my} * {33'd0, my};
                speed_sq = 66'(speed) * 66'(speed);
                if (dist_sq > speed_sq) begin
                    root_len = floor_sqrt(dist_sq);
                    if (root_len != 0) begin
                        ax = (64'(mx) * 64'(speed)) / 64'(root_len);
                        ay = (64'(my) * 64'(speed)) / 64'(root_len);
                        track_x = clamp32(dx < 0 ? track_x - longint'(ax)
                                                 : track_x + longint'(ax));
                        track_y = clamp32(dy < 0 ? track_y - longint'(ay)
                                                 : track_y + longint'(ay));
                    end
                end else begin
                    track_x = ox;
                    track_y = oy;
                end
            end
            OP_ADD: begin
                track_x = clamp32(track_x + longint'(ox));
                track_y = clamp32(track_y + longint'(oy));
            end
            default: ;
        endcase
        res.pos_x = t_fix'(track_x);
        res.pos_y = t_fix'(track_y);
        res.rel_x = t_fix'(clamp32(longint'(ox) - track_x));
        res.rel_y = t_fix'(clamp32(longint'(oy) - track_y));
        return res;
    endfunction

    assign o_pending = expected_results.size();

    // Watch both channels and the register port at each edge.
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            track_x = 0;
            track_y = 0;
            speed = 65536;
            o_errors <= 0;
            o_results <= 0;
            expected_results.delete();
        end else begin
            if (i_cfg_we) speed = i_cfg_speed;
            if (i_mon_in.valid && i_mon_in.ready) begin
                expected_results.push_back(predict_move(i_mon_in.opcode,
                    i_mon_in.operand_x, i_mon_in.operand_y));
            end
            if (i_mon_out.valid && i_mon_out.ready) begin
                got = '{i_mon_out.pos_x, i_mon_out.pos_y, i_mon_out.rel_x, i_mon_out.rel_y};
                o_results <= o_results + 1;
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, got);
                    o_errors <= o_errors + 1;
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        $display("%0t: mismatch expected pos %h,%h rel %h,%h", $time,
                                 want.pos_x, want.pos_y, want.rel_x, want.rel_y);
                        $display("%0t:          actual   pos %h,%h rel %h,%h", $time,
                                 got.pos_x, got.pos_y, got.rel_x, got.rel_y);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end
endmodule

>>> sim/tb.sv
module tb;
    import pst_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          errors;
    int          pending;
    int          results;
    int          items_sent;
    int          stall_left;
    longint      cycle_count = 0;
    bit          long_hold = 0;
    bit          hold_taken;

    pst_in_if  in_ch();
    pst_out_if out_ch();

    point_step_toward_target uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch.sink), .o_out(out_ch.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    pst_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_mon_in(in_ch.sink), .i_mon_out(out_ch.sink),
        .i_cfg_we(psel && penable && pwrite && pready && paddr == 3'd0),
        .i_cfg_speed(pwdata[30:0]), .o_errors(errors), .o_pending(pending),
        .o_results(results)
    );

    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    // Gap length: mostly short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Random coordinate, biased toward extremes and small values.
    function automatic t_fix pick_coord();
        case ($urandom_range(0, 7))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return t_fix'($urandom_range(0, 1 << 20)) - 32'sd524288;
            3: return 32'sd0;
            default: return t_fix'($urandom());
        endcase
    endfunction

    task automatic write_speed(logic [31:0] value);
        @(posedge i_clk);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= 3'd0; pwdata <= value;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
    endtask

    // Offer one item and hold it until the transfer; valid stays up for a back-to-back item.
    task automatic send_item(logic [1:0] op, t_fix x, t_fix y);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1; in_ch.opcode <= op; in_ch.operand_x <= x; in_ch.operand_y <= y;
        do @(posedge i_clk); while (!in_ch.ready);
        items_sent++;
    endtask

    // Stop offering and wait until every expected result has come out.
    task automatic drain();
        in_ch.valid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);
    endtask

    // Receiver: random stalls, plus one long hold-off on request.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 0;
            stall_left <= 0;
            hold_taken <= 0;
        end else if (long_hold && !hold_taken) begin
            hold_taken <= 1;
            stall_left <= 600;
            out_ch.ready <= 0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_ch.ready <= 0;
        end else if (out_ch.ready && $urandom_range(0, 3) == 0) begin
            stall_left <= pick_gap();
            out_ch.ready <= 0;
        end else begin
            out_ch.ready <= 1;
        end
    end

    // Watchdog on a cycle counter.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 2000000) begin
            $display("point_step_toward_target test failed");
            $finish;
        end
    end

    initial begin
        logic [31:0] speeds[5];
        logic [1:0]  op;
        speeds = '{32'h7FFF_FFFF, 32'd1, 32'h0001_0000, 32'h0040_0000, 32'hFFFF_FFFF};
        items_sent = 0;
        i_rst_n = 0; psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        in_ch.valid = 0; in_ch.opcode = OP_SET; in_ch.operand_x = 0; in_ch.operand_y = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;

        // Directed items at the reset speed of 1.0.
        send_item(OP_REL, 32'sh7FFF_FFFF, 32'sh8000_0000);
        send_item(OP_STEP, 32'sd0, 32'sd0);
        send_item(OP_STEP, 32'sd30000, -32'sd20000);
        send_item(OP_STEP, 32'sh0010_0000, -32'sh0020_0000);
        send_item(OP_SET, 32'sh7FFF_FFFF, 32'sh8000_0000);
        send_item(OP_ADD, 32'sh7FFF_FFFF, 32'sh8000_0000);
        send_item(OP_REL, 32'sh8000_0000, 32'sh7FFF_FFFF);
        send_item(OP_STEP, 32'sh8000_0000, 32'sh7FFF_FFFF);
        send_item(OP_ADD, 32'sh8000_0000, 32'sh7FFF_FFFF);
        send_item(OP_SET, 32'sd0, 32'sd0);
        drain();
        // Zero speed leaves the position in place unless already on target.
        write_speed(32'h8000_0000);
        send_item(OP_STEP, 32'sh0001_0000, 32'sh0001_0000);
        send_item(OP_STEP, 32'sd0, 32'sd0);
        send_item(OP_STEP, 32'sh8000_0000, 32'sh8000_0000);
        drain();

        // Random phases, each at a new speed; one carries the long hold-off.
        for (int ph = 0; ph < 9; ph++) begin
            write_speed(ph < 5 ? speeds[ph] : $urandom());
            if (ph == 2) long_hold <= 1;
            for (int k = 0; k < 150; k++) begin
                op = $urandom_range(0, 9) < 5 ? OP_STEP : 2'($urandom_range(0, 3));
                send_item(op, pick_coord(), pick_coord());
            end
            drain();
        end

        $display("Sent %0d items over eleven speed settings; %0d results checked.",
                 items_sent, results);
        if (errors == 0 && pending == 0) begin
            $display("point_step_toward_target test passed");
        end else begin
            $display("point_step_toward_target test failed");
        end
        $finish;
    end
endmodule

>>> point_step_toward_target.f
rtl/pst_pkg.sv
rtl/pst_in_if.sv
rtl/pst_out_if.sv
rtl/pst_mul.sv
rtl/pst_trial.sv
rtl/point_step_toward_target.sv
sim/pst_checker.sv
sim/tb.sv
